// ----- rtl/msc_pkg.sv -----
// shared types, widths and codes for the masked signature classifier
package msc_pkg;

    localparam int MSC_ENTRY_COUNT  = 64;
    localparam int MSC_PREFIX_BYTES = 32;
    localparam int PATTERN_SLOTS    = 32;

    localparam int OP_W    = 2;
    localparam int ENTRY_W = 6;
    localparam int POS_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int CFG_W   = 7;

    // input opcodes, code 3 is ignored
    localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
    localparam logic [OP_W-1:0] OP_LENGTH  = 2'd1;
    localparam logic [OP_W-1:0] OP_HEADER  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENTRY_RD,
        ST_ENTRY_CHK,
        ST_BYTE_RD,
        ST_BYTE_CMP,
        ST_DONE
    } msc_state_t;

endpackage

// ----- rtl/msc_if.sv -----
// channel interfaces: input items, results and the configuration write
interface msc_in_if import msc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] pattern_byte;
    logic [BYTE_W-1:0] mask_byte;
    logic [LEN_W-1:0]  match_length;
    logic [BYTE_W-1:0] type_code;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, op, entry, position, pattern_byte, mask_byte,
                    match_length, type_code, data_byte, last, input ready);
    modport sink (input valid, op, entry, position, pattern_byte, mask_byte,
                  match_length, type_code, data_byte, last, output ready);
endinterface

interface msc_out_if import msc_pkg::*;;
    logic               valid;
    logic               ready;
    logic               matched;
    logic [BYTE_W-1:0]  found_type;
    logic [ENTRY_W-1:0] found_entry;

    modport source (output valid, matched, found_type, found_entry, input ready);
    modport sink (input valid, matched, found_type, found_entry, output ready);
endinterface

interface msc_cfg_if import msc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/masked_signature_classifier.sv -----
// masked signature classifier: header collection and table walk over a shared comparator
// table writes and non-final header beats are taken in idle, and ready stays high for the next beat
// final header beat: walks the entries in use through entry read and check, and per compared byte
// through byte read and compare, set by the single-port table reads and the one-byte masked comparator
// result waits in an output register; a final beat holds in its last step while that is full
// reset clears sequencer, byte count, entry count and output valid; tables and header undefined
module masked_signature_classifier
    import msc_pkg::*;
#(
    parameter int ENTRY_COUNT  = MSC_ENTRY_COUNT,
    parameter int PREFIX_BYTES = MSC_PREFIX_BYTES
)
(
    input  logic          clk,
    input  logic          rst_n,
    msc_cfg_if.sink       cfg,
    msc_in_if.sink        item,
    msc_out_if.source     result
);

    // table row index and entry walk counter widths
    localparam int EA     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int ECW    = $clog2(ENTRY_COUNT + 1);
    localparam int LW     = (ECW > CFG_W) ? ECW : CFG_W;
    // header buffer address and byte count widths
    localparam int HDR_AW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
    localparam int CNTW   = $clog2(PREFIX_BYTES + 1);
    localparam int PM_D   = ENTRY_COUNT * PATTERN_SLOTS;

    // pattern and mask bytes packed per slot, length and type packed per entry
    logic [2*BYTE_W-1:0]      pm_mem  [PM_D];
    logic [LEN_W+BYTE_W-1:0]  lt_mem  [ENTRY_COUNT];
    logic [BYTE_W-1:0]        hdr_mem [PREFIX_BYTES];

    logic [2*BYTE_W-1:0]      pm_q;
    logic [LEN_W+BYTE_W-1:0]  lt_q;
    logic [BYTE_W-1:0]        hdr_q;

    msc_state_t               state_reg, state_next;
    logic [LW-1:0]            ent_reg, ent_next;
    logic [POS_W-1:0]         byte_reg, byte_next;
    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic [CFG_W-1:0]         in_use_reg;

    // scratch result of the walk
    logic                     hit_reg, hit_next;
    logic [BYTE_W-1:0]        hit_type_reg, hit_type_next;
    logic [ENTRY_W-1:0]       hit_entry_reg, hit_entry_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_matched_reg;
    logic [BYTE_W-1:0]        out_type_reg;
    logic [ENTRY_W-1:0]       out_entry_reg;
    logic                     out_load;

    logic                     pm_we, lt_we, hdr_we;
    logic                     entry_ok;
    logic [LW-1:0]            limit;
    logic [LEN_W-1:0]         len;
    logic                     byte_miss;

    assign cfg.ready = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.matched     = out_matched_reg;
    assign result.found_type  = out_type_reg;
    assign result.found_entry = out_entry_reg;

    // writes beyond the table are dropped
    assign entry_ok = LW'(item.entry) < LW'(ENTRY_COUNT);

    // entries checked, clipped to the table size
    assign limit = (LW'(in_use_reg) < LW'(ENTRY_COUNT)) ? LW'(in_use_reg) : LW'(ENTRY_COUNT);

    assign len = lt_q[LEN_W+BYTE_W-1:BYTE_W];

    // the shared masked byte comparator
    assign byte_miss = ((hdr_q & pm_q[BYTE_W-1:0])
                        != (pm_q[2*BYTE_W-1:BYTE_W] & pm_q[BYTE_W-1:0]));

    // table and header memories, registered reads at the walk position
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pm_mem[{EA'(item.entry), item.position}] <= {item.pattern_byte, item.mask_byte};
        end
        pm_q <= pm_mem[{EA'(ent_reg), byte_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (lt_we)
        begin
            lt_mem[EA'(item.entry)] <= {item.match_length, item.type_code};
        end
        lt_q <= lt_mem[EA'(ent_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[HDR_AW'(cnt_reg)] <= item.data_byte;
        end
        hdr_q <= hdr_mem[HDR_AW'(byte_reg)];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ent_reg       <= '0;
            byte_reg      <= '0;
            cnt_reg       <= '0;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ent_reg       <= ent_next;
            byte_reg      <= byte_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                in_use_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_reg       <= hit_next;
        hit_type_reg  <= hit_type_next;
        hit_entry_reg <= hit_entry_next;
        if (out_load)
        begin
            out_matched_reg <= hit_reg;
            out_type_reg    <= hit_type_reg;
            out_entry_reg   <= hit_entry_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        byte_next      = byte_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        hit_type_next  = hit_type_reg;
        hit_entry_next = hit_entry_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_load       = 1'b0;
        item.ready     = 1'b0;
        pm_we          = 1'b0;
        lt_we          = 1'b0;
        hdr_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    if (item.op == OP_PATTERN)
                    begin
                        pm_we = entry_ok;
                    end
                    else if (item.op == OP_LENGTH)
                    begin
                        lt_we = entry_ok;
                    end
                    else if (item.op == OP_HEADER)
                    begin
                        // keep only the leading bytes, count saturates
                        if (cnt_reg < CNTW'(PREFIX_BYTES))
                        begin
                            hdr_we   = 1'b1;
                            cnt_next = cnt_reg + CNTW'(1);
                        end
                        if (item.last)
                        begin
                            ent_next   = '0;
                            state_next = ST_ENTRY_RD;
                        end
                    end
                end
            end

            ST_ENTRY_RD:
            begin
                if (ent_reg >= limit)
                begin
                    // walked every entry in use without a hit
                    hit_next       = 1'b0;
                    hit_type_next  = '0;
                    hit_entry_next = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_ENTRY_CHK;
                end
            end

            ST_ENTRY_CHK:
            begin
                if ((len > LEN_W'(PATTERN_SLOTS)) || (7'(len) > 7'(cnt_reg)))
                begin
                    ent_next   = ent_reg + LW'(1);
                    state_next = ST_ENTRY_RD;
                end
                else if (len == '0)
                begin
                    // empty signature always matches
                    hit_next       = 1'b1;
                    hit_type_next  = lt_q[BYTE_W-1:0];
                    hit_entry_next = ENTRY_W'(ent_reg);
                    state_next     = ST_DONE;
                end
                else
                begin
                    byte_next  = '0;
                    state_next = ST_BYTE_RD;
                end
            end

            ST_BYTE_RD:
            begin
                state_next = ST_BYTE_CMP;
            end

            ST_BYTE_CMP:
            begin
                if (byte_miss)
                begin
                    ent_next   = ent_reg + LW'(1);
                    state_next = ST_ENTRY_RD;
                end
                else if ((LEN_W'(byte_reg) + LEN_W'(1)) == len)
                begin
                    hit_next       = 1'b1;
                    hit_type_next  = lt_q[BYTE_W-1:0];
                    hit_entry_next = ENTRY_W'(ent_reg);
                    state_next     = ST_DONE;
                end
                else
                begin
                    byte_next  = byte_reg + POS_W'(1);
                    state_next = ST_BYTE_RD;
                end
            end

            ST_DONE:
            begin
                // hand over once the output register is free, new header starts
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- dv/tb_masked_signature_classifier.sv -----
// self-checking testbench for the masked signature classifier
`timescale 1ns / 1ps

module tb_masked_signature_classifier;
    import msc_pkg::*;

    // op code 3 is not decoded by the block and must be dropped silently
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RUN_CYCLE_LIMIT = 12_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 32;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 36;
    localparam int PHASE_RESULTS   = 4;
    localparam int DIRECTED_ROWS   = 23;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  pattern_byte;
        logic [BYTE_W-1:0]  mask_byte;
        logic [LEN_W-1:0]   match_length;
        logic [BYTE_W-1:0]  type_code;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } msc_beat_t;

    typedef struct packed {
        logic               matched;
        logic [BYTE_W-1:0]  found_type;
        logic [ENTRY_W-1:0] found_entry;
    } msc_result_t;

    // directed rows: a plain beat, a beat whose class is known by inspection,
    // or a write of the entries-in-use register
    typedef enum logic [1:0] {ROW_BEAT, ROW_TYPED, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        msc_beat_t        beat;
        msc_result_t      typed_result;
        logic [CFG_W-1:0] cfg_value;
    } directed_row_t;

    localparam msc_result_t NO_RESULT = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic recv_ready = 1'b0;

    msc_cfg_if cfg_if ();
    msc_in_if  item_if ();
    msc_out_if result_if ();

    assign result_if.ready = recv_ready;

    masked_signature_classifier DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .item   (item_if),
        .result (result_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // predictor state: signature table, header prefix, entry count register
    // the loaded flags keep the stimulus away from never-written entries
    // ---------------------------------------------------------------------
    logic [BYTE_W-1:0] sig_pattern [MSC_ENTRY_COUNT][PATTERN_SLOTS];
    logic [BYTE_W-1:0] sig_mask    [MSC_ENTRY_COUNT][PATTERN_SLOTS];
    logic [LEN_W-1:0]  sig_length  [MSC_ENTRY_COUNT];
    logic [BYTE_W-1:0] sig_type    [MSC_ENTRY_COUNT];
    bit                slot_loaded   [MSC_ENTRY_COUNT][PATTERN_SLOTS];
    bit                length_loaded [MSC_ENTRY_COUNT];
    logic [BYTE_W-1:0] header_bytes [MSC_PREFIX_BYTES];
    int                header_count = 0;
    logic [CFG_W-1:0]  model_entries_in_use = '0;

    // classes still owed by the block, oldest first
    msc_result_t pending_classes [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int phase_items    = 0;
    int phase_results  = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;

    // directed stimulus: table writes, masked compares, zero and oversize
    // lengths, short headers, ignored opcode, last on table writes, empty table
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty table after reset: nothing is checked, no match
        '{ROW_TYPED, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'hFF, 1'b1},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_PATTERN, 6'd0, 5'd0, 8'h89, 8'hFF, 6'd0, 8'h00, 8'h00, 1'b0},
          NO_RESULT, 7'd0},
        // partial mask on the second byte
        '{ROW_BEAT, '{OP_PATTERN, 6'd0, 5'd1, 8'h50, 8'hDF, 6'd0, 8'h00, 8'h00, 1'b0},
          NO_RESULT, 7'd0},
        // last set on a table write is ignored
        '{ROW_BEAT, '{OP_LENGTH, 6'd0, 5'd0, 8'h00, 8'h00, 6'd2, 8'h11, 8'h00, 1'b1},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_PATTERN, 6'd1, 5'd31, 8'hFF, 8'h00, 6'd0, 8'h00, 8'h00, 1'b1},
          NO_RESULT, 7'd0},
        // zero length always matches
        '{ROW_BEAT, '{OP_LENGTH, 6'd1, 5'd0, 8'h00, 8'h00, 6'd0, 8'hFF, 8'h00, 1'b0},
          NO_RESULT, 7'd0},
        // top entry with a length past the pattern
        '{ROW_BEAT, '{OP_LENGTH, 6'd63, 5'd0, 8'h00, 8'h00, 6'd63, 8'hAA, 8'h00, 1'b0},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_UNUSED, 6'd63, 5'd31, 8'hFF, 8'hFF, 6'd63, 8'hFF, 8'hFF, 1'b1},
          NO_RESULT, 7'd0},
        '{ROW_CONFIG, '0, NO_RESULT, 7'd2},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h89, 1'b0},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h70, 1'b1},
          NO_RESULT, 7'd0},
        // one byte is too short for entry 0, entry 1 has zero length
        '{ROW_TYPED, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h89, 1'b1},
          '{1'b1, 8'hFF, 6'd1}, 7'd0},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h00, 1'b0},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h50, 1'b1},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_LENGTH, 6'd1, 5'd0, 8'h00, 8'h00, 6'd33, 8'h00, 8'h00, 1'b0},
          NO_RESULT, 7'd0},
        '{ROW_TYPED, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h89, 1'b1},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h89, 1'b0},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h50, 1'b1},
          NO_RESULT, 7'd0},
        // all-zero mask compares nothing
        '{ROW_BEAT, '{OP_PATTERN, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h00, 1'b0},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h12, 1'b0},
          NO_RESULT, 7'd0},
        '{ROW_BEAT, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'hD0, 1'b1},
          NO_RESULT, 7'd0},
        '{ROW_CONFIG, '0, NO_RESULT, 7'd0},
        '{ROW_TYPED, '{OP_HEADER, 6'd0, 5'd0, 8'h00, 8'h00, 6'd0, 8'h00, 8'h00, 1'b1},
          NO_RESULT, 7'd0}
    };

    task automatic report_mismatch(input string what);
        $display("ERROR: %s (cycle %0d)", what, cycle_count);
        mismatch_count++;
    endtask

    // updates the predictor with one accepted beat; returns 1 when the beat
    // closes a header, with the class the block owes for it
    function automatic bit predict_classification(input msc_beat_t b, output msc_result_t r);
        int limit;
        int len;
        bit hit;
        r = NO_RESULT;
        case (b.op)
            OP_PATTERN:
            begin
                sig_pattern[b.entry][b.position] = b.pattern_byte;
                sig_mask[b.entry][b.position]    = b.mask_byte;
                slot_loaded[b.entry][b.position] = 1'b1;
                return 1'b0;
            end
            OP_LENGTH:
            begin
                sig_length[b.entry]    = b.match_length;
                sig_type[b.entry]      = b.type_code;
                length_loaded[b.entry] = 1'b1;
                return 1'b0;
            end
            OP_HEADER:
            begin
                // bytes past the prefix are dropped, the count saturates
                if (header_count < MSC_PREFIX_BYTES)
                begin
                    header_bytes[header_count] = b.data_byte;
                    header_count++;
                end
                if (!b.last)
                    return 1'b0;
                // register values above the table size walk the whole table
                limit = (model_entries_in_use < MSC_ENTRY_COUNT) ?
                        int'(model_entries_in_use) : MSC_ENTRY_COUNT;
                for (int e = 0; e < limit && !r.matched; e++)
                begin
                    len = sig_length[e];
                    hit = (len <= PATTERN_SLOTS) && (len <= header_count);
                    for (int k = 0; k < len && hit; k++)
                        if ((header_bytes[k] & sig_mask[e][k]) !=
                            (sig_pattern[e][k] & sig_mask[e][k]))
                            hit = 1'b0;
                    if (hit)
                        r = '{1'b1, sig_type[e], ENTRY_W'(e)};
                end
                header_count = 0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic msc_beat_t random_beat();
        // every field random, the caller overrides what the sequence needs
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(msc_beat_t)-1:0];
    endfunction

    task automatic drive_beat(input msc_beat_t b);
        item_if.op           <= b.op;
        item_if.entry        <= b.entry;
        item_if.position     <= b.position;
        item_if.pattern_byte <= b.pattern_byte;
        item_if.mask_byte    <= b.mask_byte;
        item_if.match_length <= b.match_length;
        item_if.type_code    <= b.type_code;
        item_if.data_byte    <= b.data_byte;
        item_if.last         <= b.last;
    endtask

    // offers one beat, optionally after random idle cycles; valid is left high
    // so back-to-back beats never see valid dropped and raised in one step
    task automatic send_beat(input msc_beat_t b, input bit has_typed = 1'b0,
                             input msc_result_t typed = NO_RESULT);
        msc_result_t predicted;
        bit owed;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        drive_beat(b);
        item_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        owed = predict_classification(b, predicted);
        if (owed)
        begin
            pending_classes.push_back(has_typed ? typed : predicted);
            phase_results++;
        end
        if (b.op != OP_UNUSED)
            phase_items++;
    endtask

    // block idle: no class owed and trailing table writes retired
    task automatic wait_for_drain();
        item_if.valid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entries_in_use(input logic [CFG_W-1:0] value);
        wait_for_drain();
        cfg_if.data  <= value;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        model_entries_in_use = value;
    endtask

    // loads the pattern bytes an entry needs, then its length and type;
    // without rewrite only never-written positions are filled
    task automatic load_signature(input int e, input int len, input bit rewrite);
        msc_beat_t b;
        for (int k = 0; k < len && k < PATTERN_SLOTS; k++)
            if (rewrite || !slot_loaded[e][k])
            begin
                b          = random_beat();
                b.op       = OP_PATTERN;
                b.entry    = ENTRY_W'(e);
                b.position = POS_W'(k);
                if ($urandom_range(1) == 0)
                    b.mask_byte = 8'hFF;
                else if ($urandom_range(3) == 0)
                    b.mask_byte = 8'h00;
                send_beat(b);
            end
        b              = random_beat();
        b.op           = OP_LENGTH;
        b.entry        = ENTRY_W'(e);
        b.match_length = LEN_W'(len);
        send_beat(b);
    endtask

    // header of hlen beats; a shaped header follows the target's masked
    // pattern, with the free bits random and now and then one bit flipped
    task automatic send_header(input int target, input bit shaped, input int hlen);
        msc_beat_t b;
        logic [BYTE_W-1:0] keep;
        for (int k = 0; k < hlen; k++)
        begin
            b      = random_beat();
            b.op   = OP_HEADER;
            b.last = (k == hlen - 1);
            if (shaped && k < PATTERN_SLOTS && k < sig_length[target])
            begin
                keep = sig_mask[target][k];
                b.data_byte = (sig_pattern[target][k] & keep) | (b.data_byte & ~keep);
                if ($urandom_range(19) == 0)
                    b.data_byte = b.data_byte ^ BYTE_W'(1 << $urandom_range(7));
            end
            send_beat(b);
        end
    endtask

    // result side: check each accepted beat, then pick next cycle's ready
    always @(posedge clk)
    begin : result_monitor
        msc_result_t want;
        if (rst_n && result_if.valid === 1'b1 && recv_ready)
        begin
            if (pending_classes.size() == 0)
                report_mismatch($sformatf("result beat with no class owed: %0b %02h %0d",
                                          result_if.matched, result_if.found_type,
                                          result_if.found_entry));
            else
            begin
                want = pending_classes.pop_front();
                if (result_if.matched !== want.matched)
                    report_mismatch($sformatf("matched %0b, expected %0b",
                                              result_if.matched, want.matched));
                if (result_if.found_type !== want.found_type)
                    report_mismatch($sformatf("found_type %02h, expected %02h",
                                              result_if.found_type, want.found_type));
                if (result_if.found_entry !== want.found_entry)
                    report_mismatch($sformatf("found_entry %0d, expected %0d",
                                              result_if.found_entry, want.found_entry));
            end
        end
        recv_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    initial
    begin : watchdog
        while (cycle_count < RUN_CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        msc_beat_t b;
        int pick;
        int lim;
        int target;
        int hlen;
        int len;
        int e;
        bit shaped;
        logic [CFG_W-1:0] setting;

        drive_beat('0);
        item_if.valid <= 1'b0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (directed_rows[i])
            case (directed_rows[i].kind)
                ROW_CONFIG: write_entries_in_use(directed_rows[i].cfg_value);
                ROW_TYPED:  send_beat(directed_rows[i].beat, 1'b1, directed_rows[i].typed_result);
                default:    send_beat(directed_rows[i].beat);
            endcase

        // give every untouched entry a length past the pattern: it never
        // matches and reads no pattern byte, so any entry count is safe
        for (int i = 0; i < MSC_ENTRY_COUNT; i++)
            if (!length_loaded[i])
            begin
                b              = random_beat();
                b.op           = OP_LENGTH;
                b.entry        = ENTRY_W'(i);
                b.match_length = LEN_W'($urandom_range(33, 63));
                send_beat(b);
            end

        // random part: idle patterns rotate, entry count changes per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 75; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 75; end
                default: begin gap_pct = 36; stall_pct = 36; end
            endcase
            case (phase)
                0, 7:    setting = 7'd64;
                1:       setting = 7'd127;
                3:       setting = 7'd1;
                5:       setting = 7'd65;
                default: setting = CFG_W'($urandom_range(2, 63));
            endcase
            write_entries_in_use(setting);
            phase_items   = 0;
            phase_results = 0;
            lim = (setting < MSC_ENTRY_COUNT) ? int'(setting) : MSC_ENTRY_COUNT;

            while (phase_items < PHASE_ITEMS || phase_results < PHASE_RESULTS)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    // header, mostly shaped after an entry in use
                    target = $urandom_range(lim - 1);
                    shaped = $urandom_range(9) < 7;
                    if ($urandom_range(19) == 0)
                        hlen = $urandom_range(33, 40);
                    else if (shaped && sig_length[target] <= PATTERN_SLOTS &&
                             $urandom_range(9) != 0)
                        hlen = sig_length[target] + $urandom_range(2);
                    else
                        hlen = $urandom_range(1, 6);
                    if (hlen == 0)
                        hlen = 1;
                    send_header(target, shaped, hlen);
                end
                else if (pick < 60)
                begin
                    // reload a signature, mostly short and in use
                    e = ($urandom_range(9) < 7) ? $urandom_range(lim - 1) : $urandom_range(63);
                    len = $urandom_range(99);
                    if (len < 10)
                        len = 0;
                    else if (len < 60)
                        len = $urandom_range(1, 4);
                    else if (len < 85)
                        len = $urandom_range(5, 32);
                    else
                        len = $urandom_range(33, 63);
                    load_signature(e, len, $urandom_range(9) < 6);
                end
                else if (pick < 75)
                begin
                    // stray pattern write anywhere: may define new bytes or overwrite loaded ones
                    b    = random_beat();
                    b.op = OP_PATTERN;
                    send_beat(b);
                end
                else if (pick < 85)
                begin
                    b    = random_beat();
                    b.op = OP_UNUSED;
                    send_beat(b);
                end
                else if (pick < 95)
                    send_header(0, 1'b0, 1);
                else
                begin
                    // oversize length: entry disabled without reading bytes
                    b              = random_beat();
                    b.op           = OP_LENGTH;
                    b.match_length = LEN_W'($urandom_range(33, 63));
                    send_beat(b);
                end
            end
        end

        wait_for_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
